// ----- hdl/blfb_pkg.sv -----
package blfb_pkg;

  // Default display size
  localparam int DEF_PIXELS_X = 512;
  localparam int DEF_PIXELS_Y = 256;

  // Default store address width: row bits plus byte-column bits
  localparam int DEF_ROW_BYTES = (DEF_PIXELS_X + 7) / 8;
  localparam int DEF_COL_W     = (DEF_ROW_BYTES > 1) ? $clog2(DEF_ROW_BYTES) : 1;
  localparam int DEF_ADDR_W    = $clog2(DEF_PIXELS_Y) + DEF_COL_W;

  localparam int COORD_W = 12;
  localparam int DELTA_W = 12;   // |x1-x0| and |y1-y0| fit unsigned
  localparam int ERR_W   = 15;   // Bresenham error term, signed

  localparam logic [7:0] LEFT_BIT = 8'h80;

  // Command codes
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Raster operations
  localparam logic [1:0] ROP_SET  = 2'd0;
  localparam logic [1:0] ROP_XOR  = 2'd1;
  localparam logic [1:0] ROP_AND  = 2'd2;
  localparam logic [1:0] ROP_OR   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } line_t;

  // One pixel beat from the line walker
  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
  } pix_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_DRAW,
    S_DRAIN,
    S_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_PREP,
    W_INIT,
    W_STEP
  } walk_state_t;

endpackage

// ----- hdl/blfb_mem.sv -----
module blfb_mem
  import blfb_pkg::*;
#(
  parameter int ADDR_W = DEF_ADDR_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on a same-cycle collision; caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/blfb_walk.sv -----
module blfb_walk
  import blfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  line_t line_i,
  output pix_t  pix_o
);

  walk_state_t st_r, st_nxt;

  coord_t                    x_r, y_r;
  logic [DELTA_W-1:0]        dx_r, dy_r, cnt_r;
  logic                      sx_neg_r, sy_neg_r, x_major_r;
  logic signed [ERR_W-1:0]   e_r, up_r, flat_r;

  logic signed [COORD_W:0]   dx_full, dy_full;
  logic [DELTA_W-1:0]        dx_abs, dy_abs, d_maj, d_min;
  logic                      x_major;
  logic [ERR_W-1:0]          min2, maj1, maj2;
  logic                      last;

  // PREP: signed deltas and their magnitudes
  always_comb begin
    dx_full = {line_i.x1[COORD_W-1], line_i.x1} - {line_i.x0[COORD_W-1], line_i.x0};
    dy_full = {line_i.y1[COORD_W-1], line_i.y1} - {line_i.y0[COORD_W-1], line_i.y0};
    dx_abs  = dx_full[COORD_W] ? DELTA_W'(-dx_full) : dx_full[DELTA_W-1:0];
    dy_abs  = dy_full[COORD_W] ? DELTA_W'(-dy_full) : dy_full[DELTA_W-1:0];
  end

  // INIT: major axis and error terms; y is major on a tie
  always_comb begin
    x_major = dx_r > dy_r;
    d_maj   = x_major ? dx_r : dy_r;
    d_min   = x_major ? dy_r : dx_r;
    min2    = {2'b00, d_min, 1'b0};
    maj1    = {3'b000, d_maj};
    maj2    = {2'b00, d_maj, 1'b0};
  end

  assign last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= W_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    pix_o.valid = 1'b0;
    pix_o.last  = last;
    pix_o.x     = x_r;
    pix_o.y     = y_r;
    unique case (st_r)
      W_IDLE: begin
        if (start) begin
          st_nxt = W_PREP;
        end
      end
      W_PREP: st_nxt = W_INIT;
      W_INIT: st_nxt = W_STEP;
      W_STEP: begin
        pix_o.valid = 1'b1;
        if (last) begin
          st_nxt = W_IDLE;
        end
      end
      default: st_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      W_PREP: begin
        x_r      <= line_i.x0;
        y_r      <= line_i.y0;
        dx_r     <= dx_abs;
        dy_r     <= dy_abs;
        sx_neg_r <= dx_full[COORD_W];
        sy_neg_r <= dy_full[COORD_W];
      end
      W_INIT: begin
        x_major_r <= x_major;
        cnt_r     <= d_maj;
        e_r       <= signed'(min2 - maj1);
        up_r      <= signed'(min2 - maj2);
        flat_r    <= signed'(min2);
      end
      W_STEP: begin
        if (!last) begin
          cnt_r <= cnt_r - 1'b1;
          if (!e_r[ERR_W-1]) begin
            e_r <= e_r + up_r;
            if (x_major_r) begin
              y_r <= sy_neg_r ? y_r - 12'sd1 : y_r + 12'sd1;
            end else begin
              x_r <= sx_neg_r ? x_r - 12'sd1 : x_r + 12'sd1;
            end
          end else begin
            e_r <= e_r + flat_r;
          end
          if (x_major_r) begin
            x_r <= sx_neg_r ? x_r - 12'sd1 : x_r + 12'sd1;
          end else begin
            y_r <= sy_neg_r ? y_r - 12'sd1 : y_r + 12'sd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/bresenham_line_framebuffer_top.sv -----
// Channel  | Handshake              | Payload
// in_      | in_valid / in_ready    | mode, start/end x/y, raster_op, read_row/col
// out_     | out_valid / out_ready  | read_data, was_read
//
// Accept to next accept: a line goes through accept, walker setup (PREP, INIT), one store
// read per pixel, drain of the last write and hand-off; a read goes through READ, READ_WAIT
// and DONE. The single read port of the frame store sets the pixel rate.
// Reset: a clearing pass zeroes the store; in_ready low.
// Stalls: a finished result parks in the output register; the next command is accepted
// behind it but cannot deliver until that beat is taken.
module bresenham_line_framebuffer_top
  import blfb_pkg::*;
#(
  parameter int PIXELS_X = DEF_PIXELS_X,
  parameter int PIXELS_Y = DEF_PIXELS_Y
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic signed [11:0]  in_start_x,
  input  logic signed [11:0]  in_start_y,
  input  logic signed [11:0]  in_end_x,
  input  logic signed [11:0]  in_end_y,
  input  logic [1:0]          in_raster_op,
  input  logic [7:0]          in_read_row,
  input  logic [5:0]          in_read_byte_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_read_data,
  output logic                out_was_read
);

  localparam int ROW_BYTES = (PIXELS_X + 7) / 8;
  localparam int COL_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W     = $clog2(PIXELS_Y);
  localparam int ADDR_W    = ROW_W + COL_W;

  localparam logic [11:0] PX_LIM  = 12'(PIXELS_X);
  localparam logic [11:0] PY_LIM  = 12'(PIXELS_Y);
  localparam logic [11:0] RB_LIM  = 12'(ROW_BYTES);

  typedef logic [ADDR_W-1:0] addr_t;

  top_state_t state_r, state_nxt;

  // latched command
  logic       cmd_mode_r;
  line_t      cmd_line_r;
  logic [1:0] cmd_rop_r;
  logic [7:0] cmd_row_r;
  logic [5:0] cmd_col_r;

  logic [7:0] res_data_r;
  addr_t      clr_r;

  // pixel RMW: stage 2 holds the pixel whose byte is being read back
  logic       p_valid_r, p_valid_nxt;
  addr_t      p_addr_r;
  logic [7:0] p_mask_r;

  // last write, for forwarding into the following read
  logic       lw_valid_r;
  addr_t      lw_addr_r;
  logic [7:0] lw_data_r;

  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_was_read_r;

  logic       accept, walk_start, out_load;
  pix_t       pix;
  logic       pix_on;
  addr_t      pix_addr;
  logic       rd_inrange;
  addr_t      rd_cmd_addr;

  logic       mem_rd_en;
  addr_t      mem_rd_addr;
  logic [7:0] mem_rd_data;
  logic       mem_wr_en;
  addr_t      mem_wr_addr;
  logic [7:0] mem_wr_data;
  logic [7:0] old_byte, new_byte;

  blfb_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (walk_start),
    .line_i (cmd_line_r),
    .pix_o  (pix)
  );

  blfb_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign accept = in_valid && in_ready;

  // pixel on screen -> store address {row, byte column}
  assign pix_on = !pix.x[11] && !pix.y[11] &&
                  ({1'b0, pix.x[10:0]} < PX_LIM) &&
                  ({1'b0, pix.y[10:0]} < PY_LIM);
  assign pix_addr = {ROW_W'(pix.y), COL_W'(pix.x[11:3])};

  assign rd_inrange  = ({4'b0, cmd_row_r} < PY_LIM) && ({6'b0, cmd_col_r} < RB_LIM);
  assign rd_cmd_addr = {ROW_W'(cmd_row_r), COL_W'(cmd_col_r)};

  // stage 2: forward the byte written in the same cycle as this read
  always_comb begin
    old_byte = (lw_valid_r && (lw_addr_r == p_addr_r)) ? lw_data_r : mem_rd_data;
    unique case (cmd_rop_r)
      ROP_SET:  new_byte = old_byte | p_mask_r;
      ROP_XOR:  new_byte = old_byte ^ p_mask_r;
      ROP_AND:  new_byte = old_byte & p_mask_r;
      ROP_OR:   new_byte = old_byte;
      default:  new_byte = old_byte;
    endcase
  end

  // write port: clearing sweep or pixel write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = p_valid_r;
      mem_wr_addr = p_addr_r;
      mem_wr_data = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    walk_start  = 1'b0;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_cmd_addr;
    p_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_READ) begin
            state_nxt = S_READ;
          end else begin
            state_nxt  = S_DRAW;
            walk_start = 1'b1;
          end
        end
      end
      S_READ: begin
        mem_rd_en = rd_inrange;
        state_nxt = S_READ_WAIT;
      end
      S_READ_WAIT: state_nxt = S_DONE;
      S_DRAW: begin
        mem_rd_addr = pix_addr;
        if (pix.valid) begin
          mem_rd_en   = pix_on;
          p_valid_nxt = pix_on;
          if (pix.last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      p_valid_r   <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      p_valid_r  <= p_valid_nxt;
      lw_valid_r <= p_valid_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode_r    <= in_mode;
      cmd_line_r    <= '{x0: in_start_x, y0: in_start_y, x1: in_end_x, y1: in_end_y};
      cmd_rop_r     <= in_raster_op;
      cmd_row_r     <= in_read_row;
      cmd_col_r     <= in_read_byte_column;
    end
    if (state_r == S_READ_WAIT) begin
      res_data_r <= rd_inrange ? mem_rd_data : 8'h00;
    end
    p_addr_r  <= pix_addr;
    p_mask_r  <= LEFT_BIT >> pix.x[2:0];
    lw_addr_r <= p_addr_r;
    lw_data_r <= new_byte;
    if (out_load) begin
      out_read_data_r <= (cmd_mode_r == MODE_READ) ? res_data_r : 8'h00;
      out_was_read_r  <= (cmd_mode_r == MODE_READ);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_was_read  = out_was_read_r;

endmodule

// ----- hdl/blfb_checker.sv -----
module blfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_was_read
);

  // commands accepted but not yet delivered
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  // clearing pass and empty output right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("busy right after reset");

  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_read |-> out_read_data == 8'h00)
    else $error("draw result carries data");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without command");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many commands in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_was_read))
    else $error("stalled result beat changed");

endmodule

bind bresenham_line_framebuffer_top blfb_checker u_blfb_checker (.*);

// ----- dv/bresenham_line_framebuffer_top_test.sv -----
module bresenham_line_framebuffer_top_test;
  import blfb_pkg::*;

  // Clock period is 4; the limit covers the clearing pass, four full-span
  // directed lines and the rare full-range random lines, several times over.
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int RAND_ITEMS     = 1080;
  localparam int DIR_ROWS       = 26;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES    = 32;
  localparam int MAX_REPORTS    = 10;
  localparam int STORE_BYTES    = DEF_ROW_BYTES * DEF_PIXELS_Y;

  // One command beat, plus an optional expectation typed into the table.
  typedef struct packed {
    logic       mode;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    logic [1:0] rop;
    logic [7:0] row;
    logic [5:0] col;
    logic       lit;
    logic [7:0] lit_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       was_read;
  } result_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic         in_mode;
  logic signed [11:0] in_start_x;
  logic signed [11:0] in_start_y;
  logic signed [11:0] in_end_x;
  logic signed [11:0] in_end_y;
  logic [1:0]   in_raster_op;
  logic [7:0]   in_read_row;
  logic [5:0]   in_read_byte_column;
  logic         out_valid;
  logic         out_ready;
  logic [7:0]   out_read_data;
  logic         out_was_read;

  // Shadow copy of the pixel store, kept in step with accepted commands.
  logic [7:0]   shadow_fb [0:STORE_BYTES-1];
  result_t      pending_results [$];
  int           mismatch_cnt = 0;

  // Idle rates in percent of cycles; rx_hold asks the receiver for a long stall.
  int           tx_idle_pct = 29;
  int           rx_idle_pct = 56;
  bit           rx_hold = 1'b0;

  // Last on-screen start point, so reads land where lines were drawn.
  int           last_x = 0;
  int           last_y = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bresenham_line_framebuffer_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x            (in_end_x),
    .in_end_y            (in_end_y),
    .in_raster_op        (in_raster_op),
    .in_read_row         (in_read_row),
    .in_read_byte_column (in_read_byte_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_was_read        (out_was_read)
  );

  // ---------------------------------------------------------------------------
  // Pixel store predictor
  // ---------------------------------------------------------------------------

  // Off-display pixels are dropped; the walk itself carries on.
  function automatic void paint_pixel(int x, int y, logic [1:0] rop);
    int         idx;
    logic [7:0] mask;
    if (x < 0 || y < 0 || x >= DEF_PIXELS_X || y >= DEF_PIXELS_Y) return;
    idx  = y * DEF_ROW_BYTES + (x >> 3);
    mask = LEFT_BIT >> (x & 7);
    case (rop)
      ROP_SET:  shadow_fb[idx] = shadow_fb[idx] | mask;
      ROP_XOR:  shadow_fb[idx] = shadow_fb[idx] ^ mask;
      ROP_AND:  shadow_fb[idx] = shadow_fb[idx] & mask;  // wipes the other 7 bits
      default:  ;                                         // OR leaves the byte alone
    endcase
  endfunction

  // Bresenham walk; ties (|dx| == |dy|) step along y as the major axis.
  function automatic void rasterize_line(int x0, int y0, int x1, int y1, logic [1:0] rop);
    int dx, dy, sx, sy, err, up, flat, x, y;
    dx = x1 - x0;
    dy = y1 - y0;
    sx = 1;
    sy = 1;
    x  = x0;
    y  = y0;
    if (dx < 0) begin
      dx = -dx;
      sx = -1;
    end
    if (dy < 0) begin
      dy = -dy;
      sy = -1;
    end
    paint_pixel(x, y, rop);
    if (dx > dy) begin
      err  = 2 * dy - dx;
      up   = 2 * (dy - dx);
      flat = 2 * dy;
      for (int i = 0; i < dx; i++) begin
        if (err >= 0) begin
          y   += sy;
          err += up;
        end else begin
          err += flat;
        end
        x += sx;
        paint_pixel(x, y, rop);
      end
    end else begin
      err  = 2 * dx - dy;
      up   = 2 * (dx - dy);
      flat = 2 * dx;
      for (int i = 0; i < dy; i++) begin
        if (err >= 0) begin
          x   += sx;
          err += up;
        end else begin
          err += flat;
        end
        y += sy;
        paint_pixel(x, y, rop);
      end
    end
  endfunction

  // Every command yields exactly one beat; only reads carry data.
  function automatic result_t predict_result(cmd_t c);
    result_t r;
    r.read_data = 8'h00;
    r.was_read  = 1'b0;
    if (c.mode == MODE_READ) begin
      // row and column widths cannot exceed the default geometry
      r.read_data = shadow_fb[int'(c.row) * DEF_ROW_BYTES + int'(c.col)];
      r.was_read  = 1'b1;
    end else begin
      rasterize_line(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey), c.rop);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command construction
  // ---------------------------------------------------------------------------

  function automatic cmd_t mk_cmd(logic mode, int sx, int sy, int ex, int ey,
                                  logic [1:0] rop, int row, int col,
                                  logic lit, logic [7:0] lit_data);
    cmd_t c;
    c.mode     = mode;
    c.sx       = coord_t'(sx);
    c.sy       = coord_t'(sy);
    c.ex       = coord_t'(ex);
    c.ey       = coord_t'(ey);
    c.rop      = rop;
    c.row      = 8'(row);
    c.col      = 6'(col);
    c.lit      = lit;
    c.lit_data = lit_data;
    return c;
  endfunction

  // Mostly short lines around the display (cheap, hit the clipping edges),
  // some long ones, a few with fully random 12-bit ends. Unused fields get junk.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick, x0, y0, x1, y1;
    c = mk_cmd(MODE_DRAW, 0, 0, 0, 0, 2'($urandom_range(0, 3)),
               $urandom_range(0, 255), $urandom_range(0, 63), 1'b0, 8'h00);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 40) begin
      c.mode = MODE_READ;
      c.sx   = coord_t'($urandom);
      c.sy   = coord_t'($urandom);
      c.ex   = coord_t'($urandom);
      c.ey   = coord_t'($urandom);
      if (pick < 60) begin
        c.row = 8'(last_y + $urandom_range(0, 3));
        c.col = 6'(last_x >> 3);
      end
    end else begin
      x0 = $urandom_range(0, DEF_PIXELS_X + 31) - 16;
      y0 = $urandom_range(0, DEF_PIXELS_Y + 31) - 16;
      if (pick < 85) begin
        x1 = x0 + $urandom_range(0, 80) - 40;
        y1 = y0 + $urandom_range(0, 80) - 40;
      end else if (pick < 97) begin
        x1 = $urandom_range(0, DEF_PIXELS_X + 199) - 100;
        y1 = $urandom_range(0, DEF_PIXELS_Y + 199) - 100;
      end else begin
        x0 = $urandom;
        y0 = $urandom;
        x1 = $urandom;
        y1 = $urandom;
      end
      c.sx = coord_t'(x0);
      c.sy = coord_t'(y0);
      c.ex = coord_t'(x1);
      c.ey = coord_t'(y1);
      last_x = (int'(c.sx) < 0) ? 0 :
               (int'(c.sx) >= DEF_PIXELS_X) ? DEF_PIXELS_X - 1 : int'(c.sx);
      last_y = (int'(c.sy) < 0) ? 0 :
               (int'(c.sy) >= DEF_PIXELS_Y) ? DEF_PIXELS_Y - 1 : int'(c.sy);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Entered at a rising edge. Valid is only dropped when an idle cycle is
  // taken, so back-to-back beats keep it high with a single assignment.
  // The sender never idles while the receiver is held off: it keeps pushing
  // so the block backs up and drops in_ready.
  task automatic send_cmd(input cmd_t c);
    result_t want;
    while (!rx_hold && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= c.mode;
    in_start_x          <= c.sx;
    in_start_y          <= c.sy;
    in_end_x            <= c.ex;
    in_end_y            <= c.ey;
    in_raster_op        <= c.rop;
    in_read_row         <= c.row;
    in_read_byte_column <= c.col;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // Beat taken at this edge; the predictor runs even for table rows so the
    // shadow store stays in step.
    want = predict_result(c);
    if (c.lit) begin
      want.read_data = c.lit_data;
      want.was_read  = (c.mode == MODE_READ);
    end
    pending_results.push_back(want);
  endtask

  // Sender goes quiet until every outstanding result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cmd_t dir_tab [DIR_ROWS];
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_mode             = MODE_DRAW;
    in_start_x          = '0;
    in_start_y          = '0;
    in_end_x            = '0;
    in_end_y            = '0;
    in_raster_op        = ROP_SET;
    in_read_row         = '0;
    in_read_byte_column = '0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

    // Directed table. Literal expectations only where obvious: store empty
    // after reset, single corner pixels, draws answering zero.
    //                      mode       sx     sy     ex     ey    rop       row  col lit data
    dir_tab[ 0] = mk_cmd(MODE_READ,  -2048,  2047,     0,     0, ROP_XOR,    0,  0, 1, 8'h00);
    dir_tab[ 1] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,  255, 63, 1, 8'h00);
    dir_tab[ 2] = mk_cmd(MODE_DRAW,      0,     0,     0,     0, ROP_SET,  255, 63, 1, 8'h00);
    dir_tab[ 3] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,    0,  0, 1, 8'h80);
    dir_tab[ 4] = mk_cmd(MODE_DRAW,    511,   255,   511,   255, ROP_SET,    0,  0, 1, 8'h00);
    dir_tab[ 5] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,  255, 63, 1, 8'h01);
    dir_tab[ 6] = mk_cmd(MODE_DRAW,      0,     0,     0,     0, ROP_XOR,    0,  0, 1, 8'h00);
    dir_tab[ 7] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,    0,  0, 1, 8'h00);
    // full-span diagonal both ways: equal deltas, y walks as major axis
    dir_tab[ 8] = mk_cmd(MODE_DRAW,  -2048, -2048,  2047,  2047, ROP_SET,    0,  0, 0, 8'h00);
    dir_tab[ 9] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,    5,  0, 0, 8'h00);
    dir_tab[10] = mk_cmd(MODE_DRAW,   2047,  2047, -2048, -2048, ROP_XOR,    0,  0, 0, 8'h00);
    dir_tab[11] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,    5,  0, 0, 8'h00);
    // full-width horizontal, then AND wipes neighbors in one byte
    dir_tab[12] = mk_cmd(MODE_DRAW,  -2048,    10,  2047,    10, ROP_SET,  255, 63, 0, 8'h00);
    dir_tab[13] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,   10,  7, 0, 8'h00);
    dir_tab[14] = mk_cmd(MODE_DRAW,      3,    10,     3,    10, ROP_AND,    0,  0, 0, 8'h00);
    dir_tab[15] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,   10,  0, 0, 8'h00);
    // full-height vertical with OR: no change expected
    dir_tab[16] = mk_cmd(MODE_DRAW,    100, -2048,   100,  2047, ROP_OR,     0,  0, 0, 8'h00);
    dir_tab[17] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,   10, 12, 0, 8'h00);
    // clipped at the top edge, then entirely off-screen
    dir_tab[18] = mk_cmd(MODE_DRAW,      7,    -5,     7,    40, ROP_SET,    0,  0, 0, 8'h00);
    dir_tab[19] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,   20,  0, 0, 8'h00);
    dir_tab[20] = mk_cmd(MODE_DRAW,    600,   300,   700,   400, ROP_SET,    0,  0, 0, 8'h00);
    dir_tab[21] = mk_cmd(MODE_DRAW,     -1,    -1,    -1,    -1, ROP_SET,    0,  0, 0, 8'h00);
    // steep and shallow-backward lines
    dir_tab[22] = mk_cmd(MODE_DRAW,     50,     0,    60,   200, ROP_XOR,    0,  0, 0, 8'h00);
    dir_tab[23] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,  100,  6, 0, 8'h00);
    dir_tab[24] = mk_cmd(MODE_DRAW,    400,   200,    10,   180, ROP_SET,    0,  0, 0, 8'h00);
    dir_tab[25] = mk_cmd(MODE_READ,      0,     0,     0,     0, ROP_SET,  190, 25, 0, 8'h00);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // in_ready stays low through the clearing pass; send_cmd just waits.
    foreach (dir_tab[i]) send_cmd(dir_tab[i]);
    drain_results();

    // Random part in three stretches: sender 29 / receiver 56 percent idle,
    // then swapped with a long receiver stall up front, then no idling.
    repeat (RAND_ITEMS / 3) send_cmd(random_cmd());
    drain_results();

    tx_idle_pct = 56;
    rx_idle_pct = 29;
    rx_hold     = 1'b1;
    repeat (RAND_ITEMS / 3) send_cmd(random_cmd());
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RAND_ITEMS / 3) send_cmd(random_cmd());
    drain_results();

    // Grace period for any stray beat after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, or a counted hold-off when asked
  // ---------------------------------------------------------------------------

  initial begin : drive_out_ready
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 8'h00, out_read_data);
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, out_read_data);
        if (out_was_read !== want.was_read)
          report_mismatch("was_read", 8'(want.was_read), 8'(out_was_read));
      end
    end
  end

  // Hard stop if the handshakes hang.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
